### rtl/csl_pkg.sv
// Shared types, sizes and codes of the sequence locator window unit.
package csl_pkg;

  localparam int unsigned MaxSeqs   = 1024;
  localparam int unsigned IdxW      = $clog2(MaxSeqs);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned FifoDepth = 2;

  // Request type codes as they arrive on the input channel
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] boundary;
    logic [31:0] position;
    logic [31:0] ref_back_offset;
    logic [31:0] ref_window_len;
    logic [19:0] q_seg_start;
    logic [19:0] q_seg_end;
    logic [19:0] q_length;
    logic [19:0] q_left_ext;
    logic [19:0] q_right_ext;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [9:0]  seq_index;
    logic [31:0] seq_start;
    logic [31:0] seq_end;
    logic [31:0] ref_start;
    logic [31:0] ref_len;
    logic [31:0] left_gap;
    logic [19:0] qry_start;
    logic [19:0] qry_len;
  } out_item_t;

  // Classified request passed from the front to the back through the queue
  typedef struct packed {
    cmd_op_e     op;
    logic [31:0] boundary;
    logic [31:0] position;
    logic [31:0] back_off;
    logic [31:0] win_len;
    logic [19:0] q_start;
    logic [20:0] left_margin;
    logic [21:0] right_end;
    logic [19:0] q_length;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_LOC,
    ST_RDEND,
    ST_RDPREV,
    ST_CALCA,
    ST_CALCB,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic            pop;
    logic            mem_we;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            load_out;
  } back_ctl_t;

endpackage

### rtl/csl_front.sv
// Front stage: accepts requests, drops unknown types, precomputes query margins.
module csl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csl_pkg::in_item_t in_req_i,
  input  logic              cfg_we_i,
  input  logic [19:0]       cfg_wdata_i,
  input  logic              fifo_full_i,
  output logic              fifo_push_o,
  output csl_pkg::cmd_t     fifo_cmd_o
);
  import csl_pkg::*;

  logic        stg_valid_q, stg_valid_d;
  cmd_t        stg_q;
  cmd_t        cmd_d;
  logic        type_ok;
  logic        accept;
  logic [19:0] max_offset_q;

  assign fifo_push_o = stg_valid_q && !fifo_full_i;
  assign in_ready_o  = !stg_valid_q || !fifo_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign fifo_cmd_o  = stg_q;

  always_comb begin
    type_ok           = 1'b1;
    cmd_d.op          = OP_CLEAR;
    cmd_d.boundary    = in_req_i.boundary;
    cmd_d.position    = in_req_i.position;
    cmd_d.back_off    = in_req_i.ref_back_offset;
    cmd_d.win_len     = in_req_i.ref_window_len;
    cmd_d.q_start     = in_req_i.q_seg_start;
    cmd_d.left_margin = {1'b0, max_offset_q} + {1'b0, in_req_i.q_left_ext};
    cmd_d.right_end   = {2'b00, in_req_i.q_seg_end} + {2'b00, in_req_i.q_right_ext}
                        + {2'b00, max_offset_q};
    cmd_d.q_length    = in_req_i.q_length;
    unique case (in_req_i.req_type)
      REQ_CLEAR:  cmd_d.op = OP_CLEAR;
      REQ_APPEND: cmd_d.op = OP_APPEND;
      REQ_QUERY:  cmd_d.op = OP_QUERY;
      default:    type_ok  = 1'b0;
    endcase
  end

  always_comb begin
    if (accept && type_ok) begin
      stg_valid_d = 1'b1;
    end else if (fifo_push_o) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q  <= 1'b0;
      max_offset_q <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      if (cfg_we_i) begin
        max_offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && type_ok) begin
      stg_q <= cmd_d;
    end
  end

endmodule

### rtl/csl_fifo.sv
// Short command queue between the front and the back.
module csl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csl_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output csl_pkg::cmd_t head_o,
  output logic          empty_o
);
  import csl_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned FillW = $clog2(FifoDepth + 1);

  cmd_t             slot_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(FifoDepth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/csl_back.sv
// Back end: boundary table, binary search and window computation, result register.
module csl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  csl_pkg::cmd_t      fifo_head_i,
  output logic               fifo_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csl_pkg::out_item_t out_res_o
);
  import csl_pkg::*;

  logic [31:0]     mem [MaxSeqs];
  logic [31:0]     rd_data_q;

  back_state_e     state_q, state_d;
  back_ctl_t       ctl;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     last_q;
  cmd_t            cmd_q;
  logic [CntW-1:0] lo_q, hi_q;
  logic [IdxW-1:0] mid_q;
  logic            found_q;
  logic [31:0]     s_end_q, s_start_q, r_start_q, ref_len_q, left_gap_q;
  logic [19:0]     q_start_q, q_end_q, q_len_q;
  out_item_t       out_q;
  logic            out_valid_q;

  logic            append_ok;
  logic            ge;
  logic [CntW-1:0] nlo, nhi;
  logic [CntW:0]   sum_srch, sum_cmp;
  logic [CntW-1:0] lo_dec;
  logic [31:0]     pos_back;
  logic [32:0]     ref_reach;
  logic [31:0]     idx_ext;

  assign append_ok = (cnt_q < CntW'(MaxSeqs)) &&
                     ((cnt_q == '0) || (fifo_head_i.boundary > last_q));
  assign ge        = (rd_data_q >= cmd_q.position);
  assign nlo       = ge ? lo_q : CntW'(mid_q) + 1'b1;
  assign nhi       = ge ? CntW'(mid_q) : hi_q;
  assign sum_srch  = {1'b0, lo_q} + {1'b0, hi_q};
  assign sum_cmp   = {1'b0, nlo} + {1'b0, nhi};
  assign lo_dec    = lo_q - 1'b1;
  assign pos_back  = cmd_q.position - cmd_q.back_off;
  assign ref_reach = {1'b0, r_start_q} + {1'b0, cmd_q.win_len};
  assign idx_ext   = 32'(lo_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i && fifo_head_i.op == OP_QUERY) begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH:   state_d = (lo_q < hi_q) ? ST_CMP : ST_LOC;
      ST_CMP:    state_d = (nlo < nhi) ? ST_CMP : ST_LOC;
      ST_LOC:    state_d = (lo_q < cnt_q) ? ST_RDEND : ST_EMIT;
      ST_RDEND:  state_d = ST_RDPREV;
      ST_RDPREV: state_d = ST_CALCA;
      ST_CALCA:  state_d = ST_CALCB;
      ST_CALCB:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctl.pop    = !fifo_empty_i;
        ctl.mem_we = !fifo_empty_i && fifo_head_i.op == OP_APPEND && append_ok;
      end
      ST_SRCH: begin
        ctl.rd_en   = lo_q < hi_q;
        ctl.rd_addr = sum_srch[IdxW:1];
      end
      ST_CMP: begin
        ctl.rd_en   = nlo < nhi;
        ctl.rd_addr = sum_cmp[IdxW:1];
      end
      ST_LOC: begin
        ctl.rd_en   = lo_q < cnt_q;
        ctl.rd_addr = lo_q[IdxW-1:0];
      end
      ST_RDEND: begin
        ctl.rd_en   = lo_q != '0;
        ctl.rd_addr = lo_dec[IdxW-1:0];
      end
      ST_EMIT:   ctl.load_out = !out_valid_q || out_ready_i;
      default:   ctl = '0;
    endcase
  end

  assign fifo_pop_o  = ctl.pop;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (ctl.mem_we) begin
      mem[cnt_q[IdxW-1:0]] <= fifo_head_i.boundary;
    end
    if (ctl.rd_en) begin
      rd_data_q <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl.pop && fifo_head_i.op == OP_CLEAR) begin
        cnt_q <= '0;
      end else if (ctl.mem_we) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mem_we) begin
      last_q <= fifo_head_i.boundary;
    end
    if (ctl.pop && fifo_head_i.op == OP_QUERY) begin
      cmd_q <= fifo_head_i;
      lo_q  <= '0;
      hi_q  <= cnt_q;
    end
    if (ctl.rd_en && (state_q == ST_SRCH || state_q == ST_CMP)) begin
      mid_q <= ctl.rd_addr;
    end
    unique case (state_q)
      ST_CMP: begin
        lo_q <= nlo;
        hi_q <= nhi;
      end
      ST_LOC:    found_q <= lo_q < cnt_q;
      ST_RDEND:  s_end_q <= rd_data_q;
      ST_RDPREV: s_start_q <= (lo_q != '0) ? rd_data_q + 1'b1 : '0;
      ST_CALCA: begin
        r_start_q <= (cmd_q.position >= cmd_q.back_off && pos_back > s_start_q) ?
                     pos_back : s_start_q;
        q_start_q <= ({1'b0, cmd_q.q_start} > cmd_q.left_margin) ?
                     20'({1'b0, cmd_q.q_start} - cmd_q.left_margin) : '0;
        q_end_q   <= (cmd_q.right_end < {2'b00, cmd_q.q_length}) ?
                     cmd_q.right_end[19:0] : cmd_q.q_length;
      end
      ST_CALCB: begin
        // drop the window when its start lies past the delimiter or the position
        if (r_start_q > s_end_q || r_start_q > cmd_q.position) begin
          found_q <= 1'b0;
        end
        ref_len_q  <= ({1'b0, s_end_q} >= ref_reach) ? cmd_q.win_len : s_end_q - r_start_q;
        left_gap_q <= cmd_q.position - r_start_q;
        q_len_q    <= (q_end_q > q_start_q) ? q_end_q - q_start_q : '0;
      end
      default: ;
    endcase
    if (ctl.load_out) begin
      if (found_q) begin
        out_q.valid_res <= 1'b1;
        out_q.seq_index <= idx_ext[9:0];
        out_q.seq_start <= s_start_q;
        out_q.seq_end   <= s_end_q;
        out_q.ref_start <= r_start_q;
        out_q.ref_len   <= ref_len_q;
        out_q.left_gap  <= left_gap_q;
        out_q.qry_start <= q_start_q;
        out_q.qry_len   <= q_len_q;
      end else begin
        out_q <= '0;
      end
    end
  end

endmodule

### rtl/concat_seq_locator_window_unit.sv
// Top level of the sequence locator window unit.
//
// Input channel (in_valid_i / in_ready_o, payload in_req_i): clear, append and
// query requests. Clear and append give no result; request type 3 is dropped.
// Output channel (out_valid_o / out_ready_i, payload out_res_o): one result per
// query, with valid_res low and every other field zero when no sequence holds it.
// Configuration: cfg_we_i writes max_offset from cfg_wdata_i.
// A request is registered in the front stage and then waits in a two-entry
// queue. In the back, a query runs a binary search over the stored
// boundaries that reads the boundary memory once per step through its single
// registered read port. Queries are worked one at a time in the back.
// Reset empties the table (fill count only, no clearing pass) and sets
// max_offset to 0. When the receiver stalls, the result stays in the output
// register and the back waits; the queue then fills and in_ready_o drops.
module concat_seq_locator_window_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csl_pkg::in_item_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csl_pkg::out_item_t out_res_o,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i
);
  import csl_pkg::*;

  logic fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t push_cmd, head_cmd;

  csl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_cmd_o  (push_cmd)
  );

  csl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .head_o     (head_cmd),
    .empty_o    (fifo_empty)
  );

  csl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_head_i  (head_cmd),
    .fifo_pop_o   (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res_o)
  );

endmodule

### rtl/csl_checker.sv
// Port-level checks on the result channel, bound to the top level.
module csl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input csl_pkg::out_item_t out_res_o
);
  import csl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result dropped or changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.valid_res |->
      out_res_o.seq_start == '0 && out_res_o.seq_end == '0 &&
      out_res_o.ref_len == '0 && out_res_o.qry_len == '0)
    else $error("miss result carries nonzero fields");

  a_ref_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.valid_res |->
      out_res_o.ref_start >= out_res_o.seq_start &&
      out_res_o.ref_start <= out_res_o.seq_end)
    else $error("reference start outside its sequence");

  a_ref_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.valid_res |->
      out_res_o.ref_len <= out_res_o.seq_end - out_res_o.ref_start)
    else $error("reference window runs past the delimiter");

endmodule

bind concat_seq_locator_window_unit csl_checker u_csl_checker (.*);
